// ===== rtl/nfr_pkg.sv =====
`default_nettype none

package nfr_pkg;

    localparam int BLOCK_W = 24;
    localparam int POS_W   = 4;
    localparam int ACC_W   = BLOCK_W + 4;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_COMMIT   = 2'd1;
    localparam logic [1:0] KIND_ACK      = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // framing bytes
    localparam logic [7:0] START_BYTE  = 8'd17;
    localparam logic [7:0] MARKER_BYTE = 8'd18;
    localparam logic [7:0] END_BYTE    = 8'd19;
    localparam logic [7:0] LAST_BYTE   = 8'd21;
    localparam logic [7:0] DIGIT_0     = 8'h30;
    localparam logic [7:0] DIGIT_9     = 8'h39;

    localparam logic [BLOCK_W-1:0] HDR_SAT = {BLOCK_W{1'b1}};

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [7:0]         out_byte;
        logic [BLOCK_W-1:0] ack_number;
        logic               abandoned;
    } t_result;

    // highest block number before the count wraps to zero
    function automatic logic [BLOCK_W-1:0] block_limit(input int digits);
        longint unsigned p;
        p = 64'd1;
        for (int i = 0; i < digits; i++) begin
            p = p * 64'd10;
        end
        p = p - 64'd1;
        if (p > 64'hFF_FFFE) begin
            p = 64'hFF_FFFE;
        end
        return p[BLOCK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nfr_in_if.sv =====
`default_nettype none

interface nfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/nfr_out_if.sv =====
`default_nettype none

interface nfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [23:0] ack_number;
    logic        abandoned;

    modport source (output valid, output out_kind, output out_byte, output ack_number,
                    output abandoned, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input ack_number,
                    input abandoned, output ready);
endinterface

`default_nettype wire

// ===== rtl/numbered_frame_receiver.sv =====
`default_nettype none

// Receive side of a stop-and-wait transfer of numbered frames. Each input
// transaction is a start request, a received byte or a timeout tick; it
// yields at most one result: a tentative data byte, a frame commit, an ack
// request carrying the expected block number, or transfer completion. One
// transaction is taken every cycle: the frame state updates in a single pass
// and the result goes to an output register, so input is held back only
// while that register is full and the sink is not ready. A result appears
// in the cycle after its transaction is accepted.
module numbered_frame_receiver
    import nfr_pkg::*;
#(
    parameter int NUM_DIGITS = 7
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nfr_in_if.sink     i_in,
    nfr_out_if.source  o_out
);

    logic    accept;
    logic    space;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    nfr_core #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_in.req_type),
        .i_rx_byte   (i_in.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && res_valid),
        .i_res       (res),
        .i_out_ready (o_out.ready),
        .o_space     (space),
        .o_valid     (o_out.valid),
        .o_res       (out_res)
    );

    assign o_out.out_kind   = out_res.out_kind;
    assign o_out.out_byte   = out_res.out_byte;
    assign o_out.ack_number = out_res.ack_number;
    assign o_out.abandoned  = out_res.abandoned;

endmodule

`default_nettype wire

// ===== rtl/nfr_core.sv =====
`default_nettype none

module nfr_core
    import nfr_pkg::*;
#(
    parameter int NUM_DIGITS = 7
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [BLOCK_W-1:0] LIMIT    = block_limit(NUM_DIGITS);
    localparam logic [POS_W-1:0]   POS_LAST = POS_W'(NUM_DIGITS);
    localparam logic [POS_W-1:0]   POS_MARK = POS_W'(NUM_DIGITS + 1);
    localparam logic [POS_W-1:0]   POS_DATA = POS_W'(NUM_DIGITS + 2);

    logic               r_active, n_active;
    logic [POS_W-1:0]   r_frame_pos, n_frame_pos;
    logic [BLOCK_W-1:0] r_expected, n_expected;
    logic [BLOCK_W-1:0] r_header, n_header;
    logic               r_discarding, n_discarding;
    logic               r_data_emitted, n_data_emitted;

    logic               is_digit;
    logic [ACC_W-1:0]   acc;
    logic [BLOCK_W-1:0] next_block;

    assign is_digit   = (i_rx_byte >= DIGIT_0) && (i_rx_byte <= DIGIT_9);
    // header * 10 + digit, as two shifts and two adds
    assign acc        = {1'b0, r_header, 3'b000} + {3'b000, r_header, 1'b0}
                        + ACC_W'(i_rx_byte[3:0]);
    assign next_block = (r_expected >= LIMIT) ? '0 : r_expected + BLOCK_W'(1);

    always_comb begin
        n_active       = r_active;
        n_frame_pos    = r_frame_pos;
        n_expected     = r_expected;
        n_header       = r_header;
        n_discarding   = r_discarding;
        n_data_emitted = r_data_emitted;
        o_res_valid    = 1'b0;
        o_res          = '0;

        if (i_req_type == REQ_START) begin
            n_active       = 1'b1;
            n_frame_pos    = '0;
            n_expected     = '0;
            n_header       = '0;
            n_discarding   = 1'b0;
            n_data_emitted = 1'b0;
        end else if (r_active && i_req_type == REQ_TICK) begin
            // drop the partial frame and ask for the expected block again
            o_res_valid        = 1'b1;
            o_res.out_kind     = KIND_ACK;
            o_res.ack_number   = r_expected;
            o_res.abandoned    = r_data_emitted;
            n_frame_pos        = '0;
            n_header           = '0;
            n_data_emitted     = 1'b0;
            n_discarding       = 1'b0;
        end else if (r_active && i_req_type == REQ_BYTE && !r_discarding) begin
            if (r_frame_pos == '0) begin
                if (i_rx_byte != START_BYTE) begin
                    n_discarding = 1'b1;
                end else begin
                    n_frame_pos = POS_W'(1);
                end
            end else if (r_frame_pos <= POS_LAST) begin
                if (!is_digit) begin
                    n_discarding   = 1'b1;
                    n_frame_pos    = '0;
                    n_header       = '0;
                    n_data_emitted = 1'b0;
                end else begin
                    n_header    = (acc > ACC_W'(HDR_SAT)) ? HDR_SAT : acc[BLOCK_W-1:0];
                    n_frame_pos = r_frame_pos + POS_W'(1);
                end
            end else if (r_frame_pos == POS_MARK) begin
                if (i_rx_byte != MARKER_BYTE || r_header != r_expected) begin
                    n_discarding   = 1'b1;
                    n_frame_pos    = '0;
                    n_header       = '0;
                    n_data_emitted = 1'b0;
                end else begin
                    n_frame_pos = POS_DATA;
                end
            end else if (i_rx_byte == END_BYTE || i_rx_byte == LAST_BYTE) begin
                o_res_valid    = 1'b1;
                o_res.out_kind = (i_rx_byte == END_BYTE) ? KIND_COMMIT : KIND_COMPLETE;
                n_expected     = next_block;
                n_frame_pos    = '0;
                n_header       = '0;
                n_data_emitted = 1'b0;
                if (i_rx_byte == LAST_BYTE) begin
                    n_active = 1'b0;
                end
            end else begin
                o_res_valid    = 1'b1;
                o_res.out_kind = KIND_DATA;
                o_res.out_byte = i_rx_byte;
                n_data_emitted = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_frame_pos    <= '0;
            r_expected     <= '0;
            r_header       <= '0;
            r_discarding   <= 1'b0;
            r_data_emitted <= 1'b0;
        end else if (i_accept) begin
            r_active       <= n_active;
            r_frame_pos    <= n_frame_pos;
            r_expected     <= n_expected;
            r_header       <= n_header;
            r_discarding   <= n_discarding;
            r_data_emitted <= n_data_emitted;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nfr_out_reg.sv =====
`default_nettype none

module nfr_out_reg
    import nfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_out_ready,
    output logic         o_space,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // room for a new result when empty or when the held one leaves this cycle
    assign o_space = !r_valid || i_out_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire
